FILE: design/ttp_pkg.sv
// ----------------------------------------------------------------------------
// ttp_pkg: shared types and constants for the torque tangent projection
// Word formats, fixed-point widths, register indexes and the back-end states.
// ----------------------------------------------------------------------------
package ttp_pkg;

    localparam int UNIT_FRAC_BITS = 16;
    localparam int FIELD_BITS     = 20;
    localparam int OUT_BITS       = 48;
    localparam int UNIT_W         = UNIT_FRAC_BITS + 2;
    localparam int GAIN_W         = 24;
    localparam int PEAK_W         = OUT_BITS - 1;
    localparam int CFG_DATA_W     = PEAK_W;
    localparam int CFG_INDEX_W    = 2;
    localparam int QUEUE_DEPTH    = 2;

    // exact cross product, rounded cross, exact dot, rounded dot
    localparam int CROSS_W = UNIT_W + FIELD_BITS + 1;
    localparam int C_W     = CROSS_W - UNIT_FRAC_BITS;
    localparam int DOT_W   = C_W + UNIT_W + 2;
    localparam int D_W     = DOT_W - UNIT_FRAC_BITS;

    // shared multiplier operands
    localparam int OPA_W  = D_W;
    localparam int OPB_W  = GAIN_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int R_W    = PROD_W + 1;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_GYRO_GAIN   = 2'd0,
        CFG_ZERO_THRESH = 2'd1
    } cfg_index_t;

    typedef enum logic [1:0] {
        STATUS_OK   = 2'd0,
        STATUS_WARN = 2'd1,
        STATUS_OVF  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_CROSS,
        ST_DOT,
        ST_SCALE,
        ST_SAT,
        ST_EMIT
    } state_t;

    typedef struct packed {
        logic [3*UNIT_W-1:0]     magnet_vec;
        logic [3*UNIT_W-1:0]     basis_one_vec;
        logic [3*UNIT_W-1:0]     basis_two_vec;
        logic [3*FIELD_BITS-1:0] field_re_vec;
        logic [3*FIELD_BITS-1:0] field_im_vec;
        logic                    is_last_node;
    } in_word_t;

    typedef struct packed {
        logic signed [OUT_BITS-1:0] rhs_one_re;
        logic signed [OUT_BITS-1:0] rhs_two_re;
        logic signed [OUT_BITS-1:0] rhs_one_im;
        logic signed [OUT_BITS-1:0] rhs_two_im;
        logic [PEAK_W-1:0]          peak_drive;
        status_t                    final_status;
        logic                       last_out;
    } out_word_t;

    typedef struct packed {
        logic [2:0][UNIT_W-1:0]     m;
        logic [2:0][UNIT_W-1:0]     e1;
        logic [2:0][UNIT_W-1:0]     e2;
        logic [2:0][FIELD_BITS-1:0] hr;
        logic [2:0][FIELD_BITS-1:0] hi;
        logic                       last;
        logic                       im_zero;
    } job_t;

endpackage

FILE: design/torque_tangent_projection.sv
// ----------------------------------------------------------------------------
// torque_tangent_projection: per-node torque projection onto tangent basis
// Computes -gamma*(m x h) for real and imaginary drive, projects onto e1/e2,
// tracks peak magnitude and overflow, reports status on the last node.
// ----------------------------------------------------------------------------
// The back end skips the imaginary half of a node word when its imaginary field
// is all zero; every multiply goes through one shared 27x25 multiplier. The
// front end and a short job queue take new words while the back end works, and a
// finished word waits in the output register without holding up the next node.
// Registers are to be written only while idle, by the user; the block does not check.
module torque_tangent_projection #(
    parameter int QUEUE_DEPTH = ttp_pkg::QUEUE_DEPTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [ttp_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [ttp_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic                              in_valid,
    output logic                              in_stall,
    input  ttp_pkg::in_word_t                 in_word,
    output logic                              out_valid,
    input  logic                              out_stall,
    output ttp_pkg::out_word_t                out_word
);
    import ttp_pkg::*;

    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [PEAK_W-1:0] thresh_reg, thresh_next;
    logic q_full, q_push, q_pop, q_empty;
    job_t q_wdata, q_rdata;

    always_comb
    begin
        gain_next   = gain_reg;
        thresh_next = thresh_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_GYRO_GAIN:   gain_next   = cfg_data[GAIN_W-1:0];
                CFG_ZERO_THRESH: thresh_next = cfg_data[PEAK_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg   <= GAIN_W'(1);
            thresh_reg <= '0;
        end
        else
        begin
            gain_reg   <= gain_next;
            thresh_reg <= thresh_next;
        end
    end

    ttp_front u_front (
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_word  (in_word),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_wdata)
    );

    ttp_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_rdata),
        .empty     (q_empty)
    );

    ttp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .q_empty        (q_empty),
        .q_data         (q_rdata),
        .q_pop          (q_pop),
        .gyro_gain      (gain_reg),
        .zero_threshold (thresh_reg),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .out_word       (out_word)
    );

endmodule

FILE: design/ttp_front.sv
// ----------------------------------------------------------------------------
// ttp_front: input side
// Accepts node words, splits them into components and tags an all-zero
// imaginary field so the back end can skip that half.
// ----------------------------------------------------------------------------
module ttp_front (
    input  logic              in_valid,
    output logic              in_stall,
    input  ttp_pkg::in_word_t in_word,
    input  logic              q_full,
    output logic              q_push,
    output ttp_pkg::job_t     q_data
);
    import ttp_pkg::*;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            q_data.m[i]  = in_word.magnet_vec[i*UNIT_W +: UNIT_W];
            q_data.e1[i] = in_word.basis_one_vec[i*UNIT_W +: UNIT_W];
            q_data.e2[i] = in_word.basis_two_vec[i*UNIT_W +: UNIT_W];
            q_data.hr[i] = in_word.field_re_vec[i*FIELD_BITS +: FIELD_BITS];
            q_data.hi[i] = in_word.field_im_vec[i*FIELD_BITS +: FIELD_BITS];
        end
        q_data.last    = in_word.is_last_node;
        q_data.im_zero = (in_word.field_im_vec == '0);
    end

endmodule

FILE: design/ttp_queue.sv
// ----------------------------------------------------------------------------
// ttp_queue: job queue
// Short FIFO between the front and back ends.
// ----------------------------------------------------------------------------
module ttp_queue #(
    parameter int DEPTH = ttp_pkg::QUEUE_DEPTH
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  ttp_pkg::job_t push_data,
    output logic          full,
    input  logic          pop,
    output ttp_pkg::job_t pop_data,
    output logic          empty
);
    import ttp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    job_t             mem [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

endmodule

FILE: design/ttp_back.sv
// ----------------------------------------------------------------------------
// ttp_back: projection engine
// Runs cross products, projections and gain scaling on one shared
// multiplier, tracks the running peak and overflow, and holds the result word.
// ----------------------------------------------------------------------------
module ttp_back (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_empty,
    input  ttp_pkg::job_t                 q_data,
    output logic                          q_pop,
    input  logic [ttp_pkg::GAIN_W-1:0]    gyro_gain,
    input  logic [ttp_pkg::PEAK_W-1:0]    zero_threshold,
    output logic                          out_valid,
    input  logic                          out_stall,
    output ttp_pkg::out_word_t            out_word
);
    import ttp_pkg::*;

    localparam logic [CROSS_W-1:0] HALF_C = CROSS_W'(1) << (UNIT_FRAC_BITS - 1);
    localparam logic [DOT_W-1:0]   HALF_D = DOT_W'(1) << (UNIT_FRAC_BITS - 1);
    localparam logic signed [R_W-1:0] SAT_HI =
        {{(R_W-OUT_BITS+1){1'b0}}, {(OUT_BITS-1){1'b1}}};
    localparam logic signed [R_W-1:0] SAT_LO =
        {{(R_W-OUT_BITS+1){1'b1}}, {(OUT_BITS-1){1'b0}}};

    state_t state_reg, state_next;
    logic       fld_reg, fld_next;
    logic       prj_reg, prj_next;
    logic [1:0] k_reg, k_next;
    logic       half_reg, half_next;

    job_t                        job_reg, job_next;
    logic [2:0][C_W-1:0]         c_reg, c_next;
    logic signed [DOT_W-1:0]     acc_reg, acc_next;
    logic signed [D_W-1:0]       d_reg, d_next;
    logic signed [PROD_W-1:0]    prod_reg, prod_next;
    logic [3:0][OUT_BITS-1:0]    rhs_reg, rhs_next;
    logic [PEAK_W-1:0]           peak_reg, peak_next;
    logic                        ovf_reg, ovf_next;
    logic                        out_valid_reg, out_valid_next;
    out_word_t                   out_word_reg, out_word_next;

    logic signed [OPA_W-1:0]   opa;
    logic signed [OPB_W-1:0]   opb;
    logic signed [PROD_W-1:0]  prod;
    logic [1:0]                i1, i2;
    logic [2:0][FIELD_BITS-1:0] h;
    logic [2:0][UNIT_W-1:0]    e;
    logic signed [CROSS_W-1:0] diff;
    logic signed [CROSS_W-1:0] diff_rnd;
    logic signed [DOT_W-1:0]   dot_sum;
    logic signed [DOT_W-1:0]   dot_rnd;
    logic signed [R_W-1:0]     neg_v;
    logic [OUT_BITS-1:0]       r_sat;
    logic                      r_clip;
    logic [OUT_BITS-1:0]       r_mag;
    logic [PEAK_W-1:0]         r_peak;
    logic                      emit_load;
    status_t                   status;

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;
    assign emit_load = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign q_pop     = (state_reg == ST_IDLE) && !q_empty;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = ST_CROSS;
                end
            end
            ST_CROSS:
            begin
                if (half_reg && k_reg == 2'd2)
                begin
                    state_next = ST_DOT;
                end
            end
            ST_DOT:
            begin
                if (k_reg == 2'd2)
                begin
                    state_next = ST_SCALE;
                end
            end
            ST_SCALE:
            begin
                state_next = ST_SAT;
            end
            ST_SAT:
            begin
                if (!prj_reg)
                begin
                    state_next = ST_DOT;
                end
                else if (!fld_reg && !job_reg.im_zero)
                begin
                    state_next = ST_CROSS;
                end
                else
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // operand selection and shared multiplier
    always_comb
    begin
        case (k_reg)
            2'd0:    begin i1 = 2'd1; i2 = 2'd2; end
            2'd1:    begin i1 = 2'd2; i2 = 2'd0; end
            default: begin i1 = 2'd0; i2 = 2'd1; end
        endcase
        h = fld_reg ? job_reg.hi : job_reg.hr;
        e = prj_reg ? job_reg.e2 : job_reg.e1;
        case (state_reg)
            ST_CROSS:
            begin
                if (!half_reg)
                begin
                    opa = OPA_W'($signed(job_reg.m[i1]));
                    opb = OPB_W'($signed(h[i2]));
                end
                else
                begin
                    opa = OPA_W'($signed(job_reg.m[i2]));
                    opb = OPB_W'($signed(h[i1]));
                end
            end
            ST_DOT:
            begin
                opa = OPA_W'($signed(c_reg[k_reg]));
                opb = OPB_W'($signed(e[k_reg]));
            end
            default:
            begin
                opa = d_reg;
                opb = $signed({1'b0, gyro_gain});
            end
        endcase
        prod = opa * opb;
    end

    // datapath and counters
    always_comb
    begin
        fld_next      = fld_reg;
        prj_next      = prj_reg;
        k_next        = k_reg;
        half_next     = half_reg;
        job_next      = job_reg;
        c_next        = c_reg;
        acc_next      = acc_reg;
        d_next        = d_reg;
        prod_next     = prod_reg;
        rhs_next      = rhs_reg;
        peak_next     = peak_reg;
        ovf_next      = ovf_reg;
        out_word_next = out_word_reg;

        diff     = $signed(acc_reg[CROSS_W-1:0]) - $signed(prod[CROSS_W-1:0]);
        diff_rnd = diff + $signed(HALF_C);
        dot_sum  = acc_reg + $signed(prod[DOT_W-1:0]);
        dot_rnd  = dot_sum + $signed(HALF_D);

        neg_v = -$signed({prod_reg[PROD_W-1], prod_reg});
        if (neg_v > SAT_HI)
        begin
            r_sat  = SAT_HI[OUT_BITS-1:0];
            r_clip = 1'b1;
        end
        else if (neg_v < SAT_LO)
        begin
            r_sat  = SAT_LO[OUT_BITS-1:0];
            r_clip = 1'b1;
        end
        else
        begin
            r_sat  = neg_v[OUT_BITS-1:0];
            r_clip = 1'b0;
        end
        r_mag  = r_sat[OUT_BITS-1] ? (~r_sat + 1'b1) : r_sat;
        r_peak = r_mag[OUT_BITS-1] ? {PEAK_W{1'b1}} : r_mag[PEAK_W-1:0];

        if (!job_reg.last)
        begin
            status = STATUS_OK;
        end
        else if (ovf_reg)
        begin
            status = STATUS_OVF;
        end
        else if (peak_reg <= zero_threshold)
        begin
            status = STATUS_WARN;
        end
        else
        begin
            status = STATUS_OK;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    job_next  = q_data;
                    fld_next  = 1'b0;
                    prj_next  = 1'b0;
                    k_next    = 2'd0;
                    half_next = 1'b0;
                    rhs_next  = '0;
                end
            end
            ST_CROSS:
            begin
                if (!half_reg)
                begin
                    acc_next  = DOT_W'($signed(prod[CROSS_W-1:0]));
                    half_next = 1'b1;
                end
                else
                begin
                    c_next[k_reg] = diff_rnd[CROSS_W-1:UNIT_FRAC_BITS];
                    half_next     = 1'b0;
                    k_next        = (k_reg == 2'd2) ? 2'd0 : k_reg + 2'd1;
                    if (k_reg == 2'd2)
                    begin
                        prj_next = 1'b0;
                    end
                end
            end
            ST_DOT:
            begin
                if (k_reg == 2'd0)
                begin
                    acc_next = $signed(prod[DOT_W-1:0]);
                    k_next   = 2'd1;
                end
                else if (k_reg == 2'd1)
                begin
                    acc_next = dot_sum;
                    k_next   = 2'd2;
                end
                else
                begin
                    d_next = dot_rnd[DOT_W-1:UNIT_FRAC_BITS];
                    k_next = 2'd0;
                end
            end
            ST_SCALE:
            begin
                prod_next = prod;
            end
            ST_SAT:
            begin
                rhs_next[{fld_reg, prj_reg}] = r_sat;
                if (r_clip)
                begin
                    ovf_next = 1'b1;
                end
                if (r_peak > peak_reg)
                begin
                    peak_next = r_peak;
                end
                if (!prj_reg)
                begin
                    prj_next = 1'b1;
                end
                else if (!fld_reg && !job_reg.im_zero)
                begin
                    fld_next = 1'b1;
                    prj_next = 1'b0;
                end
            end
            ST_EMIT:
            begin
                if (emit_load)
                begin
                    out_word_next.rhs_one_re   = rhs_reg[0];
                    out_word_next.rhs_two_re   = rhs_reg[1];
                    out_word_next.rhs_one_im   = rhs_reg[2];
                    out_word_next.rhs_two_im   = rhs_reg[3];
                    out_word_next.peak_drive   = peak_reg;
                    out_word_next.final_status = status;
                    out_word_next.last_out     = job_reg.last;
                    if (job_reg.last)
                    begin
                        peak_next = '0;
                        ovf_next  = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase

        if (emit_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            fld_reg       <= 1'b0;
            prj_reg       <= 1'b0;
            k_reg         <= 2'd0;
            half_reg      <= 1'b0;
            peak_reg      <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fld_reg       <= fld_next;
            prj_reg       <= prj_next;
            k_reg         <= k_next;
            half_reg      <= half_next;
            peak_reg      <= peak_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        c_reg        <= c_next;
        acc_reg      <= acc_next;
        d_reg        <= d_next;
        prod_reg     <= prod_next;
        rhs_reg      <= rhs_next;
        out_word_reg <= out_word_next;
    end

    a_emit_fills: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_EMIT && !out_valid_reg) |=> out_valid_reg)
        else $error("emit did not load output");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_word_reg.final_status != STATUS_OK)
            |-> out_word_reg.last_out)
        else $error("status on non-last word");

    a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (emit_load && job_reg.last) |=> (peak_reg == '0 && !ovf_reg))
        else $error("running state not cleared");

    a_k_range: assert property (@(posedge clk) disable iff (!rst_n)
        k_reg != 2'd3)
        else $error("component index out of range");

endmodule

FILE: verif/torque_tangent_projection_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// torque_tangent_projection_tb: self-checking bench for the torque projection
// Streams node words through the block with random gaps and stalls on both
// sides. Each word's four projections, peak and status are predicted in the
// bench and checked in order. Covers register extremes, saturation and mesh
// status, and back-pressure that fills the block.
// ----------------------------------------------------------------------------
module torque_tangent_projection_tb;
    import ttp_pkg::*;

    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_LO = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_HI = 2'd3;
    localparam logic [UNIT_W-1:0]      U_MAX = {1'b0, {(UNIT_W-1){1'b1}}};
    localparam logic [UNIT_W-1:0]      U_MIN = {1'b1, {(UNIT_W-1){1'b0}}};
    localparam logic [UNIT_W-1:0]      U_ONE = UNIT_W'(1) << UNIT_FRAC_BITS;
    localparam logic [FIELD_BITS-1:0]  F_MAX = {1'b0, {(FIELD_BITS-1){1'b1}}};
    localparam logic [FIELD_BITS-1:0]  F_MIN = {1'b1, {(FIELD_BITS-1){1'b0}}};
    localparam longint OUT_MAX  = (64'sd1 <<< (OUT_BITS-1)) - 1;
    localparam longint OUT_MIN  = -OUT_MAX - 1;
    localparam int     DRAIN_CYCLES = 40;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_wr_en = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    in_word_t           in_word = '0;
    logic               out_valid;
    logic               out_stall = 1'b1;
    out_word_t          out_word;

    // predictor state
    logic [GAIN_W-1:0]  gyro_gain_q;
    logic [PEAK_W-1:0]  zero_thresh_q;
    logic [PEAK_W-1:0]  drive_peak_q;
    logic               overflow_q;
    logic [PEAK_W-1:0]  node_peak;

    out_word_t          pending_rhs[$];
    int                 mismatches = 0;
    int                 nodes_sent = 0;
    int                 words_checked = 0;
    int                 meshes_closed = 0;
    bit                 tx_gaps = 1'b1;
    bit                 rx_gaps = 1'b1;
    int                 rx_hold = 0;

    torque_tangent_projection dut (
        .clk(clk), .rst_n(rst_n),
        .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word)
    );

    always #10 clk = ~clk;

    function automatic longint ucomp(input logic [3*UNIT_W-1:0] v, input int i);
        return longint'($signed(v[i*UNIT_W +: UNIT_W]));
    endfunction

    function automatic longint fcomp(input logic [3*FIELD_BITS-1:0] v, input int i);
        return longint'($signed(v[i*FIELD_BITS +: FIELD_BITS]));
    endfunction

    function automatic longint round_frac(input longint v);
        return (v + (64'sd1 <<< (UNIT_FRAC_BITS-1))) >>> UNIT_FRAC_BITS;
    endfunction

    // -gamma * ((m x h) . e), saturated; updates node peak and overflow flag
    function automatic logic [OUT_BITS-1:0] project_torque(
        input logic [3*UNIT_W-1:0] mv, input logic [3*FIELD_BITS-1:0] hv,
        input logic [3*UNIT_W-1:0] ev);
        longint c0, c1, c2, d, r, a;
        c0 = round_frac(ucomp(mv,1)*fcomp(hv,2) - ucomp(mv,2)*fcomp(hv,1));
        c1 = round_frac(ucomp(mv,2)*fcomp(hv,0) - ucomp(mv,0)*fcomp(hv,2));
        c2 = round_frac(ucomp(mv,0)*fcomp(hv,1) - ucomp(mv,1)*fcomp(hv,0));
        d = round_frac(c0*ucomp(ev,0) + c1*ucomp(ev,1) + c2*ucomp(ev,2));
        r = -(d * longint'({40'd0, gyro_gain_q}));
        if (r > OUT_MAX)
        begin
            r = OUT_MAX;
            overflow_q = 1'b1;
        end
        else if (r < OUT_MIN)
        begin
            r = OUT_MIN;
            overflow_q = 1'b1;
        end
        a = (r < 0) ? -r : r;
        if (a > OUT_MAX)
            a = OUT_MAX;
        if (a > longint'({17'd0, node_peak}))
            node_peak = a[PEAK_W-1:0];
        return r[OUT_BITS-1:0];
    endfunction

    task automatic predict_node(input in_word_t w);
        out_word_t x;
        node_peak = drive_peak_q;
        x.rhs_one_re = project_torque(w.magnet_vec, w.field_re_vec, w.basis_one_vec);
        x.rhs_two_re = project_torque(w.magnet_vec, w.field_re_vec, w.basis_two_vec);
        x.rhs_one_im = project_torque(w.magnet_vec, w.field_im_vec, w.basis_one_vec);
        x.rhs_two_im = project_torque(w.magnet_vec, w.field_im_vec, w.basis_two_vec);
        x.peak_drive = node_peak;
        x.final_status = STATUS_OK;
        x.last_out = w.is_last_node;
        if (w.is_last_node)
        begin
            if (overflow_q)
                x.final_status = STATUS_OVF;
            else if (node_peak <= zero_thresh_q)
                x.final_status = STATUS_WARN;
            drive_peak_q = '0;
            overflow_q = 1'b0;
            meshes_closed++;
        end
        else
        begin
            drive_peak_q = node_peak;
        end
        pending_rhs.push_back(x);
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] exp);
        $display("MISMATCH word %0d %s: got %h expected %h", words_checked, what, got, exp);
        mismatches++;
    endtask

    // called at a falling edge; leaves valid high with the accepted word
    task automatic send_node(input in_word_t w);
        int gap;
        gap = tx_gaps ? $urandom_range(0, 11) : 0;
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid = 1'b1;
        in_word = w;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        predict_node(w);
        nodes_sent++;
        @(negedge clk);
    endtask

    task automatic wait_idle();
        in_valid = 1'b0;
        while (pending_rhs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] v);
        wait_idle();
        cfg_wr_en = 1'b1;
        cfg_index = idx;
        cfg_data = v;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (idx == CFG_GYRO_GAIN)
            gyro_gain_q = v[GAIN_W-1:0];
        else if (idx == CFG_ZERO_THRESH)
            zero_thresh_q = v;
    endtask

    function automatic in_word_t make_node(
        input logic [3*UNIT_W-1:0] m, input logic [3*UNIT_W-1:0] e1,
        input logic [3*UNIT_W-1:0] e2, input logic [3*FIELD_BITS-1:0] hr,
        input logic [3*FIELD_BITS-1:0] hi, input logic last);
        in_word_t w;
        w.magnet_vec = m;
        w.basis_one_vec = e1;
        w.basis_two_vec = e2;
        w.field_re_vec = hr;
        w.field_im_vec = hi;
        w.is_last_node = last;
        return w;
    endfunction

    function automatic logic [UNIT_W-1:0] rand_unit_comp();
        case ($urandom_range(0, 5))
            0: return U_MAX;
            1: return U_MIN;
            2: return $urandom_range(0, 1) ? U_ONE : -U_ONE;
            3: return UNIT_W'($signed($urandom_range(0, 2*U_ONE)) - $signed({1'b0, U_ONE}));
            default: return UNIT_W'($urandom);
        endcase
    endfunction

    function automatic logic [3*UNIT_W-1:0] rand_unit();
        return {rand_unit_comp(), rand_unit_comp(), rand_unit_comp()};
    endfunction

    function automatic logic [3*FIELD_BITS-1:0] rand_field();
        logic [3*FIELD_BITS-1:0] v;
        v = (3*FIELD_BITS)'({$urandom, $urandom});
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = {F_MAX, F_MIN, F_MAX};
            2: v = {3{FIELD_BITS'($signed($urandom_range(0, 64)) - 32)}};
            default: ;
        endcase
        return v;
    endfunction

    function automatic in_word_t rand_node(input logic last);
        return make_node(rand_unit(), rand_unit(), rand_unit(), rand_field(),
                         ($urandom_range(0, 3) == 0) ? '0 : rand_field(), last);
    endfunction

    always @(posedge clk)
    begin
        out_word_t exp_w;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_rhs.size() == 0)
            begin
                report_mismatch("unexpected word", out_word.rhs_one_re, '0);
            end
            else
            begin
                exp_w = pending_rhs.pop_front();
                if (out_word.rhs_one_re !== exp_w.rhs_one_re)
                    report_mismatch("rhs_one_re", out_word.rhs_one_re, exp_w.rhs_one_re);
                if (out_word.rhs_two_re !== exp_w.rhs_two_re)
                    report_mismatch("rhs_two_re", out_word.rhs_two_re, exp_w.rhs_two_re);
                if (out_word.rhs_one_im !== exp_w.rhs_one_im)
                    report_mismatch("rhs_one_im", out_word.rhs_one_im, exp_w.rhs_one_im);
                if (out_word.rhs_two_im !== exp_w.rhs_two_im)
                    report_mismatch("rhs_two_im", out_word.rhs_two_im, exp_w.rhs_two_im);
                if (out_word.peak_drive !== exp_w.peak_drive)
                    report_mismatch("peak_drive", out_word.peak_drive, exp_w.peak_drive);
                if (out_word.final_status !== exp_w.final_status)
                    report_mismatch("final_status", out_word.final_status,
                                    exp_w.final_status);
                if (out_word.last_out !== exp_w.last_out)
                    report_mismatch("last_out", out_word.last_out, exp_w.last_out);
                words_checked++;
            end
        end
    end

    // receiver: stall per word, plus an optional long hold
    initial
    begin
        int k;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (rx_hold > 0)
            begin
                out_stall = 1'b1;
                repeat (rx_hold) @(negedge clk);
                rx_hold = 0;
            end
            k = rx_gaps ? $urandom_range(0, 11) : 0;
            if (k > 0)
            begin
                out_stall = 1'b1;
                repeat (k) @(negedge clk);
            end
            out_stall = 1'b0;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
        end
    end

    task automatic test_reset_defaults();
        send_node(rand_node(1'b0));
        send_node(rand_node(1'b1));
    endtask

    task automatic test_directed_extremes();
        write_reg(CFG_GYRO_GAIN, 1);
        write_reg(CFG_ZERO_THRESH, 0);
        send_node(make_node('0, '0, '0, '0, '0, 1'b1));
        send_node(make_node({3{U_MAX}}, {3{U_MAX}}, {3{U_MAX}}, {3{F_MAX}}, {3{F_MAX}}, 1'b0));
        send_node(make_node({3{U_MIN}}, {3{U_MIN}}, {3{U_MIN}}, {3{F_MIN}}, {3{F_MIN}}, 1'b1));
        send_node(make_node({U_MIN, U_MAX, U_MAX}, {3{U_MIN}}, {U_MAX, 18'd0, U_MIN},
                            {3{F_MAX}}, {3{F_MIN}}, 1'b0));
        send_node(make_node({{2{U_ONE}}, 18'd0}, {U_ONE, 36'd0}, {18'd0, U_ONE, 18'd0},
                            {F_MIN, F_MAX, 20'd1}, '0, 1'b1));
        send_node(make_node({3{-U_ONE}}, {3{U_ONE}}, {3{-U_ONE}},
                            {20'd5, -20'd7, 20'd3}, {-20'd1, 20'd1, 20'd0}, 1'b1));
        // stray gain bits above 24 are ignored; full gain saturates outputs
        write_reg(CFG_GYRO_GAIN, '1);
        send_node(make_node({U_MIN, U_MAX, U_MIN}, {U_MAX, U_MIN, U_MAX},
                            {U_MIN, U_MIN, U_MAX}, {F_MAX, F_MIN, F_MAX}, {3{F_MIN}}, 1'b0));
        send_node(make_node({U_MAX, U_MIN, U_MAX}, {U_MAX, U_MIN, U_MAX},
                            {U_MIN, U_MAX, U_MIN}, {F_MIN, F_MAX, F_MIN}, {3{F_MAX}}, 1'b1));
        // overflow wins over the zero-drive warning
        write_reg(CFG_ZERO_THRESH, '1);
        send_node(make_node({U_MIN, U_MAX, U_MIN}, {U_MAX, U_MIN, U_MAX},
                            {U_MIN, U_MIN, U_MAX}, {F_MAX, F_MIN, F_MAX}, {3{F_MIN}}, 1'b1));
        send_node(rand_node(1'b0));
        send_node(rand_node(1'b1));
        // unused register indexes change nothing
        write_reg(CFG_SPARE_LO, '0);
        write_reg(CFG_SPARE_HI, '0);
        send_node(rand_node(1'b1));
        write_reg(CFG_GYRO_GAIN, 0);
        send_node(rand_node(1'b0));
        send_node(rand_node(1'b1));
        write_reg(CFG_ZERO_THRESH, 0);
        send_node(rand_node(1'b1));
    endtask

    task automatic test_random_meshes(input int nodes);
        int sent;
        int len;
        sent = 0;
        while (sent < nodes)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
            for (int i = 0; i < len; i++)
                send_node(rand_node(i == len - 1));
            sent += len;
            if ($urandom_range(0, 7) == 0)
            begin
                tx_gaps = ~tx_gaps;
                rx_gaps = 1'($urandom_range(0, 1));
            end
        end
    endtask

    task automatic test_settings_sweep();
        write_reg(CFG_GYRO_GAIN, 1);
        write_reg(CFG_ZERO_THRESH, 0);
        test_random_meshes(350);
        write_reg(CFG_GYRO_GAIN, 24'hFFFFFF);
        write_reg(CFG_ZERO_THRESH, '1);
        test_random_meshes(350);
        write_reg(CFG_GYRO_GAIN, $urandom_range(1, 4096));
        write_reg(CFG_ZERO_THRESH, $urandom_range(0, 1 << 20));
        test_random_meshes(550);
        write_reg(CFG_GYRO_GAIN, $urandom & 24'hFFFFFF);
        write_reg(CFG_ZERO_THRESH, CFG_DATA_W'({$urandom, $urandom}));
        test_random_meshes(550);
    endtask

    task automatic test_backpressure();
        rx_gaps = 1'b1;
        tx_gaps = 1'b0;
        rx_hold = 400;
        for (int i = 0; i < 16; i++)
            send_node(rand_node(i == 15));
        tx_gaps = 1'b1;
        // sender pause until the block has drained
        in_valid = 1'b0;
        while (pending_rhs.size() != 0)
            @(negedge clk);
        for (int i = 0; i < 60; i++)
            send_node(rand_node($urandom_range(0, 9) == 0 || i == 59));
    endtask

    initial
    begin
        gyro_gain_q = GAIN_W'(1);
        zero_thresh_q = '0;
        drive_peak_q = '0;
        overflow_q = 1'b0;
        repeat (9) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        test_reset_defaults();
        test_directed_extremes();
        test_settings_sweep();
        test_backpressure();
        in_valid = 1'b0;
        while (pending_rhs.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Covered %0d node words in %0d meshes, %0d results checked,",
                 nodes_sent, meshes_closed, words_checked);
        $display("across gain and threshold extremes, saturation and held output.");
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    initial
    begin
        #30_000_000;
        $display("Timeout with %0d results outstanding", pending_rhs.size());
        $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
design/ttp_pkg.sv
design/ttp_front.sv
design/ttp_queue.sv
design/ttp_back.sv
design/torque_tangent_projection.sv
verif/torque_tangent_projection_tb.sv
